// File: hw/rtl/qalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Operation codes, fixed-point format constants and default sizes shared by
// the quaternion ALU and its multiplier.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int FRAC_BITS           = 16;
  localparam int OP_WIDTH            = 3;

  typedef logic [OP_WIDTH-1:0] op_t;

  localparam op_t OP_ADD   = 3'd0;
  localparam op_t OP_SUB   = 3'd1;
  localparam op_t OP_MUL   = 3'd2;
  localparam op_t OP_SCALE = 3'd3;
  localparam op_t OP_CONJ  = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/qalu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion ALU multiplier
// Two-stage signed fixed-point multiplier: half-width partial products in the
// first stage, recombination and the fractional shift in the second.
// ----------------------------------------------------------------------------
module qalu_mul #(
  parameter int COMPONENT_WIDTH = qalu_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                                            clk,
  input  wire logic                                            en_pp,
  input  wire logic                                            en_sum,
  input  wire logic signed [COMPONENT_WIDTH-1:0]               x,
  input  wire logic signed [COMPONENT_WIDTH-1:0]               y,
  output logic signed [2*COMPONENT_WIDTH-qalu_pkg::FRAC_BITS-1:0] p
);
  import qalu_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int LO = W / 2;
  localparam int HI = W - LO;
  localparam int PW = 2 * W;

  logic signed [HI-1:0]      x_hi;
  logic signed [HI-1:0]      y_hi;
  logic signed [LO:0]        x_lo;
  logic signed [LO:0]        y_lo;
  logic signed [2*HI-1:0]    pp_hh;
  logic signed [HI+LO:0]     pp_hl;
  logic signed [HI+LO:0]     pp_lh;
  logic signed [2*LO+1:0]    pp_ll;
  logic signed [PW-1:0]      full;

  assign x_hi = x[W-1:LO];
  assign y_hi = y[W-1:LO];
  assign x_lo = $signed({1'b0, x[LO-1:0]});
  assign y_lo = $signed({1'b0, y[LO-1:0]});

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_hh <= x_hi * y_hi;
      pp_hl <= x_hi * y_lo;
      pp_lh <= x_lo * y_hi;
      pp_ll <= x_lo * y_lo;
    end
  end

  assign full = (PW'(pp_hh) <<< (2 * LO)) + (PW'(pp_hl) <<< LO)
              + (PW'(pp_lh) <<< LO) + PW'(pp_ll);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      p <= full[PW-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion ALU
// Add, subtract, Hamilton product, scale and conjugate on signed Q16.16
// quaternions, with per-component saturation and an overflow flag.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the four-stage pipeline (partial products,
// product recombination, component sums, saturation) only holds when m_tready
// is low and every stage is occupied.
// Reset clears the stage valid bits only; the pipeline then accepts at once.
module quaternion_alu #(
  parameter int COMPONENT_WIDTH = qalu_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  // Fields from bit 0: a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scalar.
  input  wire logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0]   s_tdata,
  // Fields from bit 0: op.
  input  wire logic [qalu_pkg::OP_WIDTH-1:0]            s_tuser,
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  // Fields from bit 0: c_real, c_i, c_j, c_k.
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]        m_tdata,
  // Fields from bit 0: overflow.
  output logic [0:0]                                    m_tuser
);
  import qalu_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int LW    = W + 1;
  localparam int PSW   = 2 * W - FRAC_BITS;
  localparam int SW    = PSW + 2;
  localparam int OUT_W = ((4 * W + 7) / 8) * 8;

  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 valid1, valid2, valid3, valid4;
  op_t                  op1, op2;

  logic signed [W-1:0]  a_in [4];
  logic signed [W-1:0]  b_in [4];
  logic signed [W-1:0]  s_in;
  logic signed [W-1:0]  mul_x [4][4];
  logic signed [PSW-1:0] prod [4][4];
  logic signed [SW-1:0] pe [4][4];

  logic signed [LW-1:0] lin_next [4];
  logic signed [LW-1:0] lin1 [4];
  logic signed [LW-1:0] lin2 [4];
  logic signed [SW-1:0] sum_next [4];
  logic signed [SW-1:0] sum3 [4];
  logic signed [W-1:0]  sat_next [4];
  logic [3:0]           ovf_bits;
  logic signed [W-1:0]  res4 [4];
  logic                 ovf4;

  assign rdy4     = !valid4 || m_tready;
  assign rdy3     = !valid3 || rdy4;
  assign rdy2     = !valid2 || rdy3;
  assign rdy1     = !valid1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (rdy1) valid1 <= s_tvalid;
      if (rdy2) valid2 <= valid1;
      if (rdy3) valid3 <= valid2;
      if (rdy4) valid4 <= valid3;
    end
  end

  for (genvar n = 0; n < 4; n++) begin : g_unpack
    assign a_in[n] = s_tdata[n*W +: W];
    assign b_in[n] = s_tdata[(n+4)*W +: W];
  end
  assign s_in = s_tdata[8*W +: W];

  // Row zero of the product array doubles as the scalar-times-b products.
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (r == 0) begin : g_scale_mux
        assign mul_x[r][c] = (s_tuser == OP_SCALE) ? s_in : a_in[r];
      end else begin : g_plain
        assign mul_x[r][c] = a_in[r];
      end

      qalu_mul #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
      ) u_mul (
        .clk   (clk),
        .en_pp (rdy1),
        .en_sum(rdy2),
        .x     (mul_x[r][c]),
        .y     (b_in[c]),
        .p     (prod[r][c])
      );

      assign pe[r][c] = SW'(prod[r][c]);
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      case (s_tuser)
        OP_ADD:  lin_next[n] = LW'(a_in[n]) + LW'(b_in[n]);
        OP_SUB:  lin_next[n] = LW'(a_in[n]) - LW'(b_in[n]);
        OP_CONJ: lin_next[n] = (n == 0) ? LW'(a_in[n]) : -LW'(a_in[n]);
        default: lin_next[n] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1  <= s_tuser;
      lin1 <= lin_next;
    end
    if (rdy2) begin
      op2  <= op1;
      lin2 <= lin1;
    end
  end

  always_comb begin
    case (op2)
      OP_MUL: begin
        sum_next[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        sum_next[1] = pe[1][0] + pe[0][1] - pe[3][2] + pe[2][3];
        sum_next[2] = pe[2][0] + pe[3][1] + pe[0][2] - pe[1][3];
        sum_next[3] = pe[3][0] - pe[2][1] + pe[1][2] + pe[0][3];
      end
      OP_SCALE: begin
        for (int n = 0; n < 4; n++) sum_next[n] = pe[0][n];
      end
      OP_ADD, OP_SUB, OP_CONJ: begin
        for (int n = 0; n < 4; n++) sum_next[n] = SW'(lin2[n]);
      end
      default: begin
        for (int n = 0; n < 4; n++) sum_next[n] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum3 <= sum_next;
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      if (sum3[n][SW-1:W-1] == {(SW-W+1){sum3[n][SW-1]}}) begin
        sat_next[n] = sum3[n][W-1:0];
        ovf_bits[n] = 1'b0;
      end else begin
        sat_next[n] = sum3[n][SW-1] ? SAT_MIN : SAT_MAX;
        ovf_bits[n] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res4 <= sat_next;
      ovf4 <= |ovf_bits;
    end
  end

  assign m_tvalid   = valid4;
  assign m_tdata    = OUT_W'({res4[3], res4[2], res4[1], res4[0]});
  assign m_tuser[0] = ovf4;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (valid1 && valid2 && valid3 && valid4))
    else $error("input blocked while a pipeline stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid1)
    else $error("accepted word did not enter the first stage");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    (valid4 && ovf4) |->
      (res4[0] == SAT_MAX || res4[0] == SAT_MIN || res4[1] == SAT_MAX ||
       res4[1] == SAT_MIN || res4[2] == SAT_MAX || res4[2] == SAT_MIN ||
       res4[3] == SAT_MAX || res4[3] == SAT_MIN))
    else $error("overflow flagged without a saturated component");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (rdy3 && valid2 && op2 != OP_ADD && op2 != OP_SUB && op2 != OP_MUL &&
     op2 != OP_SCALE && op2 != OP_CONJ) |=>
      (sum3[0] == '0 && sum3[1] == '0 && sum3[2] == '0 && sum3[3] == '0))
    else $error("undefined operation produced a nonzero sum");

endmodule

`default_nettype wire
